[design/percent_decoder_with_escape_macros.svh]
// ---------------------------------------------------------------------------
// Percent decoder assertion macros
// Shared concurrent assertion forms for the percent decoder.
// ---------------------------------------------------------------------------
`ifndef PERCENT_DECODER_WITH_ESCAPE_MACROS_SVH
`define PERCENT_DECODER_WITH_ESCAPE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCTDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("percent decoder: implication failed");

// Next-cycle implication, checked out of reset.
`define PCTDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("percent decoder: next-cycle implication failed");

`endif

[design/pctdec_pkg.sv]
// ---------------------------------------------------------------------------
// Percent decoder package
// Shared types, register indexes, character codes and hex digit decode.
// ---------------------------------------------------------------------------
package pctdec_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_BACKSLASH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_0       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_1       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_2       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_3       = 3'd4;

	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UP_A      = 8'h41;
	localparam logic [7:0] CH_UP_F      = 8'h46;
	localparam logic [7:0] CH_LO_A      = 8'h61;
	localparam logic [7:0] CH_LO_F      = 8'h66;
	localparam logic [7:0] CH_UP_BIAS   = 8'h37;
	localparam logic [7:0] CH_LO_BIAS   = 8'h57;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2
	} phase_t;

	typedef enum logic {
		BK_FIRST  = 1'b0,
		BK_SECOND = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       two;
		logic       last;
		logic       status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// {valid, value} of a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] diff;
		logic [4:0] res;
		diff = 8'd0;
		res  = 5'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			diff = c - CH_ZERO;
			res  = {1'b1, diff[3:0]};
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			diff = c - CH_UP_BIAS;
			res  = {1'b1, diff[3:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			diff = c - CH_LO_BIAS;
			res  = {1'b1, diff[3:0]};
		end
		return res;
	endfunction

endpackage

[design/percent_decoder_with_escape.sv]
// ---------------------------------------------------------------------------
// Percent decoder with backslash escaping
// Streams an encoded string one byte per transfer and emits decoded bytes.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and in_last; one byte per
// transfer, in_last on the final byte of a string.
// Output channel: out_valid/out_stall with out_byte, byte_valid, run_last,
// string_end and status. Each input byte gives zero, one or two results; the
// final byte always gives at least one, carrying string_end and status.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 selects the
// backslash enable, 1 to 4 the four 64-bit delimiter mask words. cfg_ready is
// always high; write only while the block is idle.
// Path: each job is written into the job queue, then registered in the output stage.
// Throughput: one input byte per cycle while the output is not stalled. A byte
// that needs a backslash in front occupies the output register for the backslash
// and then for the byte itself; the QUEUE_DEPTH-entry job queue absorbs short runs
// of them, and a longer run holds the input back through in_stall.
// Reset clears the escape state, error flag, configuration, queue and valid flag.
// While out_stall is high the output register holds; the queue fills and then
// in_stall rises until results drain.
// ---------------------------------------------------------------------------
module percent_decoder_with_escape #(
	parameter int QUEUE_DEPTH = pctdec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pctdec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pctdec_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          in_byte,
	input  logic                                in_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_byte,
	output logic                                byte_valid,
	output logic                                run_last,
	output logic                                string_end,
	output logic                                status
);
	import pctdec_pkg::*;

	`include "percent_decoder_with_escape_macros.svh"

	logic      q_push;
	logic      q_pop;
	job_t      q_wdata;
	job_t      q_rdata;
	q_status_t q_stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;

	pctdec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (q_push),
		.job       (q_wdata)
	);

	pctdec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	pctdec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (q_rdata),
		.stat       (q_stat),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.status     (status)
	);

	`PCTDEC_ASSERT_IMPL(a_no_overflow, clk, arst_n, q_push, !q_stat.full)
	`PCTDEC_ASSERT_IMPL(a_no_underflow, clk, arst_n, q_pop, !q_stat.empty)
	`PCTDEC_ASSERT_IMPL(a_end_is_run_last, clk, arst_n, out_valid && string_end, run_last)
	`PCTDEC_ASSERT_IMPL(a_empty_is_end, clk, arst_n, out_valid && !byte_valid,
		string_end && out_byte == 8'd0)

endmodule

[design/pctdec_front.sv]
// ---------------------------------------------------------------------------
// Percent decoder front end
// Holds configuration, tracks escape state and classifies each input byte.
// ---------------------------------------------------------------------------
module pctdec_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [pctdec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pctdec_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          in_byte,
	input  logic                                in_last,
	output logic                                push,
	output pctdec_pkg::job_t                    job
);
	import pctdec_pkg::*;

	logic         use_bs_q;
	logic [255:0] delim_q;
	phase_t       phase_q, phase_nx;
	logic [3:0]   nib_q, nib_nx;
	logic         err_q, err_nx;

	logic         accept;
	logic [4:0]   hex;
	logic [7:0]   val;
	logic         emit;
	logic         two;
	logic [7:0]   data;

	assign accept = in_valid && !in_stall;
	assign hex    = hex_decode(in_byte);
	assign val    = {nib_q, hex[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_bs_q <= 1'b0;
			delim_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_USE_BACKSLASH: use_bs_q <= cfg_data[0];
				CFG_DELIM_0:       delim_q[63:0]    <= cfg_data;
				CFG_DELIM_1:       delim_q[127:64]  <= cfg_data;
				CFG_DELIM_2:       delim_q[191:128] <= cfg_data;
				CFG_DELIM_3:       delim_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_nx = phase_q;
		nib_nx   = nib_q;
		err_nx   = err_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_HIGH: begin
					if (!hex[4]) begin
						err_nx   = 1'b1;
						phase_nx = PH_PLAIN;
					end else begin
						nib_nx   = hex[3:0];
						phase_nx = PH_LOW;
					end
				end
				PH_LOW: begin
					phase_nx = PH_PLAIN;
					if (!hex[4] || val == 8'd0) begin
						err_nx = 1'b1;
					end
				end
				default: begin
					if (in_byte == CH_PERCENT) begin
						phase_nx = PH_HIGH;
					end
				end
			endcase
		end
		if (in_last) begin
			if (phase_nx != PH_PLAIN) begin
				err_nx = 1'b1;
			end
		end
	end

	always_comb begin
		emit = 1'b0;
		two  = 1'b0;
		data = 8'd0;
		if (!err_q) begin
			unique case (phase_q)
				PH_HIGH: ;
				PH_LOW: begin
					if (hex[4] && val != 8'd0) begin
						emit = 1'b1;
						data = val;
						two  = use_bs_q && (val == CH_BACKSLASH || val == CH_PERCENT
							|| delim_q[val]);
					end
				end
				default: begin
					if (in_byte != CH_PERCENT) begin
						emit = 1'b1;
						data = in_byte;
					end
				end
			endcase
		end
		push            = accept && (emit || in_last);
		job.data        = data;
		job.data_valid  = emit;
		job.two         = two;
		job.last        = in_last;
		job.status      = in_last && err_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			nib_q   <= 4'd0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_PLAIN;
				nib_q   <= 4'd0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				nib_q   <= nib_nx;
				err_q   <= err_nx;
			end
		end
	end

endmodule

[design/pctdec_queue.sv]
// ---------------------------------------------------------------------------
// Percent decoder job queue
// Short first-in first-out buffer of classified jobs between front and back.
// ---------------------------------------------------------------------------
module pctdec_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pctdec_pkg::job_t        wdata,
	input  logic                    pop,
	output pctdec_pkg::job_t        rdata,
	output pctdec_pkg::q_status_t   stat
);
	import pctdec_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/pctdec_back.sv]
// ---------------------------------------------------------------------------
// Percent decoder back end
// Expands each job into one or two results and holds them in the output stage.
// ---------------------------------------------------------------------------
module pctdec_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pctdec_pkg::job_t        job,
	input  pctdec_pkg::q_status_t   stat,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic                    run_last,
	output logic                    string_end,
	output logic                    status
);
	import pctdec_pkg::*;

	bk_state_t  state_q, state_nx;
	logic       load;
	logic       take;
	logic       lead;
	logic       valid_q;
	logic [7:0] byte_q, byte_nx;
	logic       bval_q, bval_nx;
	logic       rlast_q, rlast_nx;
	logic       send_q, send_nx;
	logic       stat_q, stat_nx;

	assign load = !valid_q || !out_stall;
	assign take = load && !stat.empty;
	assign lead = job.two && (state_q == BK_FIRST);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_FIRST: begin
				if (take && job.two) begin
					state_nx = BK_SECOND;
				end
			end
			BK_SECOND: begin
				if (take) begin
					state_nx = BK_FIRST;
				end
			end
			default: state_nx = BK_FIRST;
		endcase
	end

	always_comb begin
		pop = take && !lead;
		if (lead) begin
			byte_nx  = CH_BACKSLASH;
			bval_nx  = 1'b1;
			rlast_nx = 1'b0;
			send_nx  = 1'b0;
			stat_nx  = 1'b0;
		end else begin
			byte_nx  = job.data;
			bval_nx  = job.data_valid;
			rlast_nx = 1'b1;
			send_nx  = job.last;
			stat_nx  = job.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FIRST;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				valid_q <= !stat.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q  <= byte_nx;
			bval_q  <= bval_nx;
			rlast_q <= rlast_nx;
			send_q  <= send_nx;
			stat_q  <= stat_nx;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign byte_valid = bval_q;
	assign run_last   = rlast_q;
	assign string_end = send_q;
	assign status     = stat_q;

endmodule
